@@ src/iss_pkg.sv @@
// shared types, constants and codes for the indexed sequence store
`timescale 1ns / 1ps

package iss_pkg;

   localparam int CAPACITY  = 64;
   localparam int WORD_BITS = 32;
   localparam int IDX_BITS  = $clog2(CAPACITY);
   localparam int CNT_BITS  = $clog2(CAPACITY + 1);
   localparam int POS_BITS  = 7;
   localparam int CMP_BITS  = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;

   localparam logic [2:0] CMD_INS_FRONT = 3'd0;
   localparam logic [2:0] CMD_INS_REAR  = 3'd1;
   localparam logic [2:0] CMD_INS_AT    = 3'd2;
   localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
   localparam logic [2:0] CMD_DEL_REAR  = 3'd4;
   localparam logic [2:0] CMD_DEL_AT    = 3'd5;
   localparam logic [2:0] CMD_READ_AT   = 3'd6;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_BADIDX = 2'd3;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [6:0]  position;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] read_value;
      logic [6:0]  count;
   } rsp_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic                ins;
      logic                del;
      logic [IDX_BITS-1:0] at;
   } shift_type;

endpackage

@@ src/indexed_sequence_store.sv @@
// Indexed sequence store: a row of cells holding an ordered list of words.
// The result of an accepted item is registered in the output register.
// Throughput: one item per cycle unless stalled; cells from the position up shift
// in the same cycle, and the output register lets a new item enter while the
// previous result is taken. Reset clears the fill count and the output valid;
// cell contents stay unknown until written, and no clearing pass is needed.
`timescale 1ns / 1ps

module indexed_sequence_store (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  iss_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output iss_pkg::rsp_type  rsp_data
);
   import iss_pkg::*;

   logic                 accept;
   shift_type            shift;
   logic                 rd_ok;
   logic [1:0]           status;
   logic [CNT_BITS-1:0]  count;
   logic [WORD_BITS-1:0] ins_word;
   logic [WORD_BITS-1:0] words [CAPACITY];
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign ins_word  = WORD_BITS'(req_data.value);

   iss_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .shift  (shift),
      .rd_ok  (rd_ok),
      .status (status),
      .count  (count)
   );

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [WORD_BITS-1:0] left_word;
      logic [WORD_BITS-1:0] right_word;

      if (g == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_left
         assign left_word = words[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_right
         assign right_word = words[g+1];
      end

      iss_cell u_cell (
         .clock      (clock),
         .cell_idx   (IDX_BITS'(g)),
         .shift      (shift),
         .ins_word   (ins_word),
         .left_word  (left_word),
         .right_word (right_word),
         .word       (words[g])
      );
   end

   always_comb begin
      rsp_in.status     = status;
      rsp_in.read_value = rd_ok ? 32'(words[shift.at]) : '0;
      rsp_in.count      = 7'(count);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ src/iss_cell.sv @@
// one storage cell of the chain: holds one entry and shifts with its neighbors
`timescale 1ns / 1ps

module iss_cell (
   input  logic                           clock,
   input  logic [iss_pkg::IDX_BITS-1:0]   cell_idx,
   input  iss_pkg::shift_type             shift,
   input  logic [iss_pkg::WORD_BITS-1:0]  ins_word,
   input  logic [iss_pkg::WORD_BITS-1:0]  left_word,
   input  logic [iss_pkg::WORD_BITS-1:0]  right_word,
   output logic [iss_pkg::WORD_BITS-1:0]  word
);
   import iss_pkg::*;

   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (shift.ins) begin
         if (cell_idx > shift.at) begin
            word_in = left_word;
         end else if (cell_idx == shift.at) begin
            word_in = ins_word;
         end
      end else if (shift.del && (cell_idx >= shift.at)) begin
         word_in = right_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

@@ src/iss_ctrl.sv @@
// command decode, status checks and the fill count
`timescale 1ns / 1ps

module iss_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  iss_pkg::req_type              req,
   output iss_pkg::shift_type            shift,
   output logic                          rd_ok,
   output logic [1:0]                    status,
   output logic [iss_pkg::CNT_BITS-1:0]  count
);
   import iss_pkg::*;

   logic [CNT_BITS-1:0] fill_ff;
   logic [CNT_BITS-1:0] fill_in;
   logic [CMP_BITS-1:0] pos_w;
   logic [CMP_BITS-1:0] fill_w;
   logic                full;
   logic                empty;
   logic                do_ins;
   logic                do_del;
   logic [IDX_BITS-1:0] at;

   assign pos_w  = CMP_BITS'(req.position);
   assign fill_w = CMP_BITS'(fill_ff);
   assign full   = (fill_ff == CNT_BITS'(CAPACITY));
   assign empty  = (fill_ff == '0);

   always_comb begin
      status = ST_OK;
      do_ins = 1'b0;
      do_del = 1'b0;
      rd_ok  = 1'b0;
      at     = '0;
      unique case (req.cmd)
         CMD_INS_FRONT: begin
            if (full) status = ST_FULL;
            else do_ins = 1'b1;
         end
         CMD_INS_REAR: begin
            at = IDX_BITS'(fill_ff);
            if (full) status = ST_FULL;
            else do_ins = 1'b1;
         end
         CMD_INS_AT: begin
            at = IDX_BITS'(req.position);
            if (full) status = ST_FULL;
            else if (pos_w > fill_w) status = ST_BADIDX;
            else do_ins = 1'b1;
         end
         CMD_DEL_FRONT: begin
            if (empty) status = ST_EMPTY;
            else do_del = 1'b1;
         end
         CMD_DEL_REAR: begin
            at = IDX_BITS'(fill_ff - CNT_BITS'(1));
            if (empty) status = ST_EMPTY;
            else do_del = 1'b1;
         end
         CMD_DEL_AT: begin
            at = IDX_BITS'(req.position);
            if (empty) status = ST_EMPTY;
            else if (pos_w >= fill_w) status = ST_BADIDX;
            else do_del = 1'b1;
         end
         CMD_READ_AT: begin
            at = IDX_BITS'(req.position);
            if (empty) status = ST_EMPTY;
            else if (pos_w >= fill_w) status = ST_BADIDX;
            else rd_ok = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      fill_in = fill_ff;
      if (accept && do_ins) fill_in = fill_ff + CNT_BITS'(1);
      else if (accept && do_del) fill_in = fill_ff - CNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign shift.ins = accept & do_ins;
   assign shift.del = accept & do_del;
   assign shift.at  = at;
   assign count     = fill_in;

endmodule

@@ tb/sv/tb.sv @@
// self-checking testbench for the indexed sequence store: directed probes, then random traffic
`timescale 1ns / 1ps

module tb;
   import iss_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_ITEMS   = 125;
   localparam int SETTLE_CYCLES = 8;
   localparam int REPORT_LINES  = 20;

   localparam logic [2:0] CMD_UNUSED = 3'd7;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type result;
   } probe_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // mirror of the list contents
   logic [WORD_BITS-1:0] list_words [CAPACITY];
   int                   list_fill = 0;
   bit                   growing   = 1'b1;

   rsp_type       expected_rsp [$];
   probe_row_type probe_rows [$];
   rsp_type       want_rsp;
   int            error_count     = 0;
   int            cycle_count     = 0;
   int            sender_idle_pct = 0;
   int            rsp_stall_pct   = 0;

   indexed_sequence_store u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("indexed_sequence_store verification failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= reset ? 1'b0 : ($urandom_range(99) < rsp_stall_pct);
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (error_count < REPORT_LINES)
         $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected item", rsp_data, 0);
         end else begin
            want_rsp = expected_rsp.pop_front();
            if (rsp_data.status !== want_rsp.status)
               report_mismatch("status", rsp_data.status, want_rsp.status);
            if (rsp_data.read_value !== want_rsp.read_value)
               report_mismatch("read_value", rsp_data.read_value, want_rsp.read_value);
            if (rsp_data.count !== want_rsp.count)
               report_mismatch("count", rsp_data.count, want_rsp.count);
         end
      end
   end

   function automatic logic [1:0] list_insert(input int at, input logic [WORD_BITS-1:0] word);
      if (list_fill >= CAPACITY)
         return ST_FULL;
      if (at > list_fill)
         return ST_BADIDX;
      for (int i = list_fill; i > at; i--)
         list_words[i] = list_words[i-1];
      list_words[at] = word;
      list_fill++;
      return ST_OK;
   endfunction

   function automatic logic [1:0] list_delete(input int at);
      if (list_fill == 0)
         return ST_EMPTY;
      if (at >= list_fill)
         return ST_BADIDX;
      for (int i = at; i + 1 < list_fill; i++)
         list_words[i] = list_words[i+1];
      list_fill--;
      return ST_OK;
   endfunction

   function automatic rsp_type apply_list_op(input req_type r);
      rsp_type res;
      res = '0;
      res.status = ST_OK;
      case (r.cmd)
         CMD_INS_FRONT: res.status = list_insert(0, r.value);
         CMD_INS_REAR:  res.status = list_insert(list_fill, r.value);
         CMD_INS_AT:    res.status = list_insert(int'(r.position), r.value);
         CMD_DEL_FRONT: res.status = list_delete(0);
         CMD_DEL_REAR:  res.status = list_delete(list_fill - 1);
         CMD_DEL_AT:    res.status = list_delete(int'(r.position));
         CMD_READ_AT: begin
            if (list_fill == 0)
               res.status = ST_EMPTY;
            else if (int'(r.position) >= list_fill)
               res.status = ST_BADIDX;
            else
               res.read_value = list_words[r.position[IDX_BITS-1:0]];
         end
         default: ;
      endcase
      res.count = list_fill[6:0];
      return res;
   endfunction

   task automatic send_item(input req_type r, input bit typed, input rsp_type typed_rsp);
      rsp_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = apply_list_op(r);
      expected_rsp.push_back(typed ? typed_rsp : predicted);
   endtask

   // hold the sender off until every result is back
   task automatic wait_list_settled();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0)
         @(posedge clock);
   endtask

   task automatic add_probe(input logic [2:0] cmd, input int pos, input logic [31:0] value,
                            input bit typed, input logic [1:0] status,
                            input logic [31:0] read_value, input int count);
      probe_row_type row;
      row.item.cmd          = cmd;
      row.item.position     = pos[6:0];
      row.item.value        = value;
      row.typed             = typed;
      row.result.status     = status;
      row.result.read_value = read_value;
      row.result.count      = count[6:0];
      probe_rows.push_back(row);
   endtask

   function automatic int pick_position();
      int r;
      r = $urandom_range(99);
      if (r < 70)
         return $urandom_range(list_fill > 0 ? list_fill - 1 : 0, 0);
      else if (r < 85)
         return list_fill;
      else if (r < 92)
         return (list_fill + 1) % 128;
      return $urandom_range(127, 0);
   endfunction

   function automatic req_type make_random_item();
      req_type r;
      int      pick;
      if (list_fill == CAPACITY && $urandom_range(3) == 0)
         growing = 1'b0;
      if (list_fill == 0 && $urandom_range(3) == 0)
         growing = 1'b1;
      r.value = $urandom;
      pick = $urandom_range(99);
      if (pick < 10) begin
         r.cmd      = 3'($urandom_range(7, 0));
         r.position = 7'($urandom_range(127, 0));
         return r;
      end
      pick = $urandom_range(99);
      if (pick < 80)
         r.cmd = growing ? 3'($urandom_range(2, 0)) : 3'($urandom_range(5, 3));
      else if (pick < 85)
         r.cmd = growing ? 3'($urandom_range(5, 3)) : 3'($urandom_range(2, 0));
      else
         r.cmd = CMD_READ_AT;
      r.position = 7'(pick_position());
      return r;
   endfunction

   initial begin
      req_type item;
      int      sent;
      add_probe(CMD_READ_AT,   0,   32'h0,        1, ST_EMPTY,  32'h0,        0);
      add_probe(CMD_DEL_FRONT, 0,   32'h0,        1, ST_EMPTY,  32'h0,        0);
      add_probe(CMD_DEL_REAR,  0,   32'h0,        1, ST_EMPTY,  32'h0,        0);
      add_probe(CMD_DEL_AT,    0,   32'h0,        1, ST_EMPTY,  32'h0,        0);
      add_probe(CMD_INS_AT,    1,   32'h1234_5678, 1, ST_BADIDX, 32'h0,       0);
      add_probe(CMD_INS_FRONT, 0,   32'hFFFF_FFFF, 1, ST_OK,    32'h0,        1);
      add_probe(CMD_INS_REAR,  127, 32'h0,        1, ST_OK,     32'h0,        2);
      add_probe(CMD_INS_AT,    2,   32'hA5A5_A5A5, 1, ST_OK,    32'h0,        3);
      add_probe(CMD_INS_AT,    1,   32'h5A5A_5A5A, 1, ST_OK,    32'h0,        4);
      add_probe(CMD_READ_AT,   0,   32'h0,        1, ST_OK,     32'hFFFF_FFFF, 4);
      add_probe(CMD_READ_AT,   3,   32'h0,        0, ST_OK,     32'h0,        0);
      add_probe(CMD_READ_AT,   4,   32'h0,        1, ST_BADIDX, 32'h0,        4);
      add_probe(CMD_READ_AT,   127, 32'h0,        1, ST_BADIDX, 32'h0,        4);
      // unused command code leaves the list alone
      add_probe(CMD_UNUSED,    5,   32'hFFFF_FFFF, 1, ST_OK,    32'h0,        4);
      add_probe(CMD_DEL_AT,    4,   32'h0,        1, ST_BADIDX, 32'h0,        4);
      add_probe(CMD_DEL_AT,    1,   32'h0,        0, ST_OK,     32'h0,        0);
      add_probe(CMD_DEL_FRONT, 0,   32'h0,        0, ST_OK,     32'h0,        0);
      add_probe(CMD_DEL_REAR,  0,   32'h0,        0, ST_OK,     32'h0,        0);
      add_probe(CMD_READ_AT,   0,   32'h0,        0, ST_OK,     32'h0,        0);
      add_probe(CMD_INS_AT,    64,  32'h0,        1, ST_BADIDX, 32'h0,        1);
      add_probe(CMD_DEL_AT,    127, 32'h0,        1, ST_BADIDX, 32'h0,        1);
      add_probe(CMD_DEL_AT,    0,   32'h0,        1, ST_OK,     32'h0,        0);
      add_probe(CMD_READ_AT,   0,   32'h0,        1, ST_EMPTY,  32'h0,        0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 6;  rsp_stall_pct = 51; end
            1: begin sender_idle_pct = 51; rsp_stall_pct = 6;  end
            default: begin sender_idle_pct = 0; rsp_stall_pct = 0; end
         endcase
         if (phase == 0)
            foreach (probe_rows[i])
               send_item(probe_rows[i].item, probe_rows[i].typed, probe_rows[i].result);
         sent = 0;
         while (sent < PHASE_ITEMS + 10) begin
            item = make_random_item();
            send_item(item, 1'b0, '0);
            if (item.cmd != CMD_UNUSED)
               sent++;
         end
         wait_list_settled();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_rsp.size() == 0)
         $display("indexed_sequence_store verification clean");
      else
         $display("indexed_sequence_store verification failed");
      $finish;
   end

endmodule
